@@ src/cbm_pkg.sv @@
// shared types, codes and constants for the bank mapper with scanline irq
package cbm_pkg;

  localparam int PRG_BANKS   = 2;
  localparam int CHR_BANKS   = 6;
  localparam int BANK_W      = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CHR_IDX_W   = $clog2(CHR_BANKS);

  localparam int CPU_ADDR_W  = 16;
  localparam int PPU_ADDR_W  = 14;
  localparam int CYCLE_W     = 9;
  localparam int PRG_ROM_W   = 21;
  localparam int CHR_ROM_W   = 18;

  localparam logic [CYCLE_W-1:0] IRQ_CLOCK_DOT = 9'd264;
  localparam logic [BANK_W-1:0]  MASK_RESET    = 8'hFF;
  localparam int                 MIRROR_BIT    = 6;

  typedef enum logic [1:0] {
    REQ_CPU_WRITE = 2'd0,
    REQ_PPU_TICK  = 2'd1,
    REQ_PRG_XLATE = 2'd2,
    REQ_CHR_XLATE = 2'd3
  } req_t;

  // cpu write groups, decoded from address bits 14:13
  typedef enum logic [1:0] {
    WGRP_BANK_LO = 2'd0,
    WGRP_CHR_HI  = 2'd1,
    WGRP_IRQ     = 2'd2,
    WGRP_MIRROR  = 2'd3
  } wgrp_t;

  // irq group registers, decoded from address bits 1:0
  typedef enum logic [1:0] {
    IRQ_SEL_LATCH   = 2'd0,
    IRQ_SEL_RELOAD  = 2'd1,
    IRQ_SEL_ENABLE  = 2'd2,
    IRQ_SEL_DISABLE = 2'd3
  } irq_sel_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PRG_MASK = 1'b0,
    CFG_CHR_MASK = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    req_t                  req_type;
    logic [CPU_ADDR_W-1:0] cpu_addr;
    logic [7:0]            write_data;
    logic [PPU_ADDR_W-1:0] ppu_addr;
    logic [CYCLE_W-1:0]    ppu_cycle;
    logic                  rendering;
  } item_t;

  typedef struct packed {
    logic [BANK_W-1:0]                prg_mask;
    logic [BANK_W-1:0]                chr_mask;
    logic [PRG_BANKS-1:0][BANK_W-1:0] prg_bank;
    logic [CHR_BANKS-1:0][BANK_W-1:0] chr_bank;
    logic                             mirror_select;
    logic [BANK_W-1:0]                irq_count;
    logic [BANK_W-1:0]                irq_reload_value;
    logic                             reload_pending;
    logic                             irq_enable;
    logic                             irq_pending;
  } map_state_t;

  typedef struct packed {
    logic [PRG_ROM_W-1:0] prg_rom_addr;
    logic                 prg_hit;
    logic [CHR_ROM_W-1:0] chr_rom_addr;
    logic                 nametable_a10;
  } xlate_t;

endpackage

@@ src/cartridge_bank_mapper_scanline_irq.sv @@
// Bank mapper with scanline irq: decodes CPU writes into bank and irq
// registers, counts scanlines on PPU ticks and translates CPU and PPU
// addresses into program and pattern ROM byte addresses.
// Input channel: in_valid/in_stall carry one item (req_type plus all fields);
// it is accepted when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall carry exactly one result per item, in
// order: prg_rom_addr, prg_hit, chr_rom_addr, nametable_a10, irq_line.
// Flow: an accepted item waits in the input register; when it advances, it is
// applied to the mapper registers and its result is registered at the same edge.
// Throughput: one item per cycle while the receiver does not stall, set by the
// input and result registers with the single decode/translate level between them.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, then in_stall rises until the result drains.
// Config: cfg_write with cfg_index 0 (program mask) or 1 (pattern mask) and
// cfg_data, written only while the block is idle; the user must keep to this, the block does not enforce it.
// Reset (rst, synchronous): both masks 0xFF, program banks 0 and 1, pattern
// banks 0..5, mirroring, irq counter, latch and flags cleared; no result valid.
module cartridge_bank_mapper_scanline_irq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          req_type,
  input  logic [cbm_pkg::CPU_ADDR_W-1:0]      cpu_addr,
  input  logic [7:0]                          write_data,
  input  logic [cbm_pkg::PPU_ADDR_W-1:0]      ppu_addr,
  input  logic [cbm_pkg::CYCLE_W-1:0]         ppu_cycle,
  input  logic                                rendering,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cbm_pkg::PRG_ROM_W-1:0]       prg_rom_addr,
  output logic                                prg_hit,
  output logic [cbm_pkg::CHR_ROM_W-1:0]       chr_rom_addr,
  output logic                                nametable_a10,
  output logic                                irq_line
);
  import cbm_pkg::*;

  item_t      in_item;
  item_t      s1_item;
  logic       s1_valid;
  logic       advance;
  map_state_t st;
  logic       irq_next;
  xlate_t     xl;

  assign in_item = '{
    req_type:   req_t'(req_type),
    cpu_addr:   cpu_addr,
    write_data: write_data,
    ppu_addr:   ppu_addr,
    ppu_cycle:  ppu_cycle,
    rendering:  rendering
  };

  // item moves into the result register when that register is free or draining
  assign advance = s1_valid && (!out_valid || !out_stall);

  cbm_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  cbm_state u_state (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (s1_item),
    .st        (st),
    .irq_next  (irq_next)
  );

  cbm_xlate u_xlate (
    .item (s1_item),
    .st   (st),
    .res  (xl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prg_rom_addr  <= xl.prg_rom_addr;
      prg_hit       <= xl.prg_hit;
      chr_rom_addr  <= xl.chr_rom_addr;
      nametable_a10 <= xl.nametable_a10;
      irq_line      <= irq_next;
    end
  end

endmodule

@@ src/cbm_in_stage.sv @@
// input register stage with stall back to the sender
module cbm_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cbm_pkg::item_t in_item,
  input  logic          advance,
  output logic          valid,
  output cbm_pkg::item_t item
);
  import cbm_pkg::*;

  logic load;

  // the stage frees up in the same cycle its item moves on
  assign in_stall = valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

@@ src/cbm_state.sv @@
// mapper registers: bank numbers, mirroring, irq counter and config masks
module cbm_state (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                fire,
  input  cbm_pkg::item_t                      item,
  output cbm_pkg::map_state_t                 st,
  output logic                                irq_next
);
  import cbm_pkg::*;

  map_state_t           st_next;
  wgrp_t                grp;
  irq_sel_t             isel;
  logic [1:0]           sel;
  logic [CHR_IDX_W-1:0] chr_idx;
  logic [BANK_W-1:0]    count_new;
  logic                 take_reload;

  assign grp  = wgrp_t'(item.cpu_addr[14:13]);
  assign sel  = item.cpu_addr[1:0];
  assign isel = irq_sel_t'(sel);

  always_comb begin
    st_next     = st;
    chr_idx     = '0;
    take_reload = (st.irq_count == '0) || st.reload_pending;
    count_new   = take_reload ? st.irq_reload_value : st.irq_count - 8'd1;

    if (fire) begin
      unique case (item.req_type)
        REQ_CPU_WRITE: begin
          if (item.cpu_addr[15]) begin
            unique case (grp)
              WGRP_BANK_LO: begin
                if (!sel[1]) begin
                  st_next.prg_bank[sel[0]] = item.write_data;
                end else begin
                  chr_idx = {{(CHR_IDX_W-1){1'b0}}, sel[0]};
                  st_next.chr_bank[chr_idx] = item.write_data;
                end
              end
              WGRP_CHR_HI: begin
                chr_idx = CHR_IDX_W'(2) + {1'b0, sel};
                st_next.chr_bank[chr_idx] = item.write_data;
              end
              WGRP_IRQ: begin
                unique case (isel)
                  IRQ_SEL_LATCH:  st_next.irq_reload_value = ~item.write_data;
                  IRQ_SEL_RELOAD: begin
                    st_next.irq_count      = '0;
                    st_next.reload_pending = 1'b1;
                  end
                  IRQ_SEL_ENABLE: st_next.irq_enable = 1'b1;
                  IRQ_SEL_DISABLE: begin
                    st_next.irq_enable  = 1'b0;
                    st_next.irq_pending = 1'b0;
                  end
                  default: ;
                endcase
              end
              WGRP_MIRROR: begin
                if (sel == 2'd0) begin
                  st_next.mirror_select = item.write_data[MIRROR_BIT];
                end
              end
              default: ;
            endcase
          end
        end
        REQ_PPU_TICK: begin
          if (item.rendering && item.ppu_cycle == IRQ_CLOCK_DOT) begin
            st_next.irq_count = count_new;
            // fires only on a transition into zero, not when parked at zero
            if ((st.irq_count != '0 || st.reload_pending) && count_new == '0 &&
                st.irq_enable) begin
              st_next.irq_pending = 1'b1;
            end
            st_next.reload_pending = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PRG_MASK: st_next.prg_mask = cfg_data;
        CFG_CHR_MASK: st_next.chr_mask = cfg_data;
        default: ;
      endcase
    end
  end

  assign irq_next = st_next.irq_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.prg_mask         <= MASK_RESET;
      st.chr_mask         <= MASK_RESET;
      for (int i = 0; i < PRG_BANKS; i++) begin
        st.prg_bank[i] <= BANK_W'(i);
      end
      for (int i = 0; i < CHR_BANKS; i++) begin
        st.chr_bank[i] <= BANK_W'(i);
      end
      st.mirror_select    <= 1'b0;
      st.irq_count        <= '0;
      st.irq_reload_value <= '0;
      st.reload_pending   <= 1'b0;
      st.irq_enable       <= 1'b0;
      st.irq_pending      <= 1'b0;
    end else begin
      st <= st_next;
    end
  end

endmodule

@@ src/cbm_xlate.sv @@
// address translation for program and pattern rom plus nametable a10
module cbm_xlate (
  input  cbm_pkg::item_t      item,
  input  cbm_pkg::map_state_t st,
  output cbm_pkg::xlate_t     res
);
  import cbm_pkg::*;

  logic                 a13;
  logic [BANK_W-1:0]    prg_sel;
  logic [BANK_W-1:0]    prg_bank;
  logic [BANK_W-1:0]    chr_raw;
  logic [BANK_W-1:0]    chr_bank;
  logic [CHR_IDX_W-1:0] chr_idx;
  logic [CHR_IDX_W-1:0] chr_lo_idx;

  assign a13 = item.cpu_addr[13];

  always_comb begin
    // c000-ffff is fixed to the last 16 kb
    if (item.cpu_addr[14]) begin
      prg_sel = {st.prg_mask[BANK_W-1:1], a13};
    end else begin
      prg_sel = st.prg_bank[a13];
    end
    prg_bank = prg_sel & st.prg_mask;

    chr_idx    = CHR_IDX_W'(2) + {1'b0, item.ppu_addr[11:10]};
    chr_lo_idx = CHR_IDX_W'(item.ppu_addr[11]);
    if (item.ppu_addr[12]) begin
      chr_raw = st.chr_bank[chr_idx];
    end else begin
      // 2 kb banks: bank number doubled, a10 picks the half
      chr_raw = {st.chr_bank[chr_lo_idx][BANK_W-2:0], item.ppu_addr[10]};
    end
    chr_bank = chr_raw & st.chr_mask;

    res = '0;
    unique case (item.req_type)
      REQ_PRG_XLATE: begin
        if (item.cpu_addr[15]) begin
          res.prg_rom_addr = {prg_bank, item.cpu_addr[12:0]};
          res.prg_hit      = 1'b1;
        end
      end
      REQ_CHR_XLATE: begin
        if (!item.ppu_addr[13]) begin
          res.chr_rom_addr = {chr_bank, item.ppu_addr[9:0]};
        end
        res.nametable_a10 = st.mirror_select ? item.ppu_addr[11] : item.ppu_addr[10];
      end
      default: ;
    endcase
  end

endmodule

@@ tb/cartridge_bank_mapper_scanline_irq_tb.sv @@
// testbench for the bank mapper: predicts bank mapping, irq counting and translations
module cartridge_bank_mapper_scanline_irq_tb;
  import cbm_pkg::*;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 305;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    xlate_t xl;
    logic   irq;
  } map_result_t;

  // mirror of the mapper registers plus the translations still owed by the block
  class mapper_tracker;
    logic [BANK_W-1:0] prg_mask;
    logic [BANK_W-1:0] chr_mask;
    logic [BANK_W-1:0] prg_bank [PRG_BANKS];
    logic [BANK_W-1:0] chr_bank [CHR_BANKS];
    logic              mirror_select;
    logic [BANK_W-1:0] irq_count;
    logic [BANK_W-1:0] irq_reload_value;
    logic              reload_pending;
    logic              irq_enable;
    logic              irq_pending;
    map_result_t       owed_translations [$];
    int                errors;

    function new();
      prg_mask = MASK_RESET;
      chr_mask = MASK_RESET;
      for (int i = 0; i < PRG_BANKS; i++) prg_bank[i] = BANK_W'(i);
      for (int i = 0; i < CHR_BANKS; i++) chr_bank[i] = BANK_W'(i);
      mirror_select    = 1'b0;
      irq_count        = '0;
      irq_reload_value = '0;
      reload_pending   = 1'b0;
      irq_enable       = 1'b0;
      irq_pending      = 1'b0;
      errors           = 0;
    endfunction

    function void decode_write(logic [CPU_ADDR_W-1:0] addr, logic [7:0] data);
      logic [1:0] sel;
      sel = addr[1:0];
      if (!addr[15]) return;
      case (wgrp_t'(addr[14:13]))
        WGRP_BANK_LO: begin
          if (sel[1]) chr_bank[CHR_IDX_W'(sel[0])] = data;
          else prg_bank[sel[0]] = data;
        end
        WGRP_CHR_HI: chr_bank[CHR_IDX_W'(2 + sel)] = data;
        WGRP_IRQ: begin
          case (irq_sel_t'(sel))
            IRQ_SEL_LATCH:  irq_reload_value = ~data;
            IRQ_SEL_RELOAD: begin
              irq_count      = '0;
              reload_pending = 1'b1;
            end
            IRQ_SEL_ENABLE: irq_enable = 1'b1;
            default: begin
              irq_enable  = 1'b0;
              irq_pending = 1'b0;
            end
          endcase
        end
        default: if (sel == 2'd0) mirror_select = data[MIRROR_BIT];
      endcase
    endfunction

    function void clock_scanline(logic [CYCLE_W-1:0] cycle, logic rendering);
      logic [BANK_W-1:0] old_count;
      if (!rendering || cycle != IRQ_CLOCK_DOT) return;
      old_count = irq_count;
      if (irq_count == '0 || reload_pending) irq_count = irq_reload_value;
      else irq_count = irq_count - 1'b1;
      if ((old_count != '0 || reload_pending) && irq_count == '0 && irq_enable)
        irq_pending = 1'b1;
      reload_pending = 1'b0;
    endfunction

    function map_result_t map_and_translate(item_t it);
      map_result_t       r;
      logic [BANK_W-1:0] bank;
      logic [BANK_W:0]   chr_unit;
      r = '0;
      case (it.req_type)
        REQ_CPU_WRITE: decode_write(it.cpu_addr, it.write_data);
        REQ_PPU_TICK:  clock_scanline(it.ppu_cycle, it.rendering);
        REQ_PRG_XLATE: begin
          if (it.cpu_addr[15]) begin
            // upper 16 KB sits on the last two banks that the mask allows
            if (it.cpu_addr[14]) bank = {prg_mask[BANK_W-1:1], it.cpu_addr[13]};
            else bank = prg_bank[it.cpu_addr[13]];
            bank = bank & prg_mask;
            r.xl.prg_rom_addr = {bank, it.cpu_addr[12:0]};
            r.xl.prg_hit      = 1'b1;
          end
        end
        default: begin
          if (!it.ppu_addr[13]) begin
            if (it.ppu_addr[12])
              chr_unit = {1'b0, chr_bank[CHR_IDX_W'(2 + it.ppu_addr[11:10])]};
            else
              chr_unit = {chr_bank[CHR_IDX_W'(it.ppu_addr[11])], it.ppu_addr[10]};
            bank = chr_unit[BANK_W-1:0] & chr_mask;
            r.xl.chr_rom_addr = {bank, it.ppu_addr[9:0]};
          end
          r.xl.nametable_a10 = mirror_select ? it.ppu_addr[11] : it.ppu_addr[10];
        end
      endcase
      r.irq = irq_pending;
      return r;
    endfunction

    function void note_item(item_t it);
      owed_translations.push_back(map_and_translate(it));
    endfunction

    function void check_result(map_result_t got);
      map_result_t want;
      if (owed_translations.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      want = owed_translations.pop_front();
      if (got.xl.prg_rom_addr !== want.xl.prg_rom_addr) begin
        $error("prg_rom_addr: expected %h, got %h", want.xl.prg_rom_addr, got.xl.prg_rom_addr);
        errors++;
      end
      if (got.xl.prg_hit !== want.xl.prg_hit) begin
        $error("prg_hit: expected %b, got %b", want.xl.prg_hit, got.xl.prg_hit);
        errors++;
      end
      if (got.xl.chr_rom_addr !== want.xl.chr_rom_addr) begin
        $error("chr_rom_addr: expected %h, got %h", want.xl.chr_rom_addr, got.xl.chr_rom_addr);
        errors++;
      end
      if (got.xl.nametable_a10 !== want.xl.nametable_a10) begin
        $error("nametable_a10: expected %b, got %b", want.xl.nametable_a10,
               got.xl.nametable_a10);
        errors++;
      end
      if (got.irq !== want.irq) begin
        $error("irq_line: expected %b, got %b", want.irq, got.irq);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_PRG_MASK;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             req_type = REQ_CPU_WRITE;
  logic [CPU_ADDR_W-1:0]  cpu_addr = '0;
  logic [7:0]             write_data = '0;
  logic [PPU_ADDR_W-1:0]  ppu_addr = '0;
  logic [CYCLE_W-1:0]     ppu_cycle = '0;
  logic                   rendering = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PRG_ROM_W-1:0]   prg_rom_addr;
  logic                   prg_hit;
  logic [CHR_ROM_W-1:0]   chr_rom_addr;
  logic                   nametable_a10;
  logic                   irq_line;

  mapper_tracker tracker = new();
  logic          tx_calm = 1'b0;
  logic          rx_calm = 1'b0;
  logic          long_hold_req = 1'b0;
  int            quiet_cycles = 0;

  cartridge_bank_mapper_scanline_irq dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .cpu_addr(cpu_addr), .write_data(write_data),
    .ppu_addr(ppu_addr), .ppu_cycle(ppu_cycle), .rendering(rendering),
    .out_valid(out_valid), .out_stall(out_stall),
    .prg_rom_addr(prg_rom_addr), .prg_hit(prg_hit), .chr_rom_addr(chr_rom_addr),
    .nametable_a10(nametable_a10), .irq_line(irq_line)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic item_t fresh_item(req_t kind);
    item_t it;
    it.req_type   = kind;
    it.cpu_addr   = CPU_ADDR_W'($urandom);
    it.write_data = 8'($urandom);
    it.ppu_addr   = PPU_ADDR_W'($urandom);
    it.ppu_cycle  = CYCLE_W'($urandom_range(0, 340));
    it.rendering  = 1'($urandom);
    return it;
  endfunction

  function automatic item_t write_item(logic [CPU_ADDR_W-1:0] addr, logic [7:0] data);
    item_t it;
    it = fresh_item(REQ_CPU_WRITE);
    it.cpu_addr   = addr;
    it.write_data = data;
    return it;
  endfunction

  function automatic item_t tick_item(logic [CYCLE_W-1:0] cycle, logic rend);
    item_t it;
    it = fresh_item(REQ_PPU_TICK);
    it.ppu_cycle = cycle;
    it.rendering = rend;
    return it;
  endfunction

  function automatic item_t prg_item(logic [CPU_ADDR_W-1:0] addr);
    item_t it;
    it = fresh_item(REQ_PRG_XLATE);
    it.cpu_addr = addr;
    return it;
  endfunction

  function automatic item_t chr_item(logic [PPU_ADDR_W-1:0] addr);
    item_t it;
    it = fresh_item(REQ_CHR_XLATE);
    it.ppu_addr = addr;
    return it;
  endfunction

  // mostly mapper writes and dot-264 ticks so the irq counter actually runs
  function automatic item_t random_item();
    item_t it;
    int    pick;
    int    r;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it = fresh_item(REQ_PPU_TICK);
      if ($urandom_range(0, 2) != 0) begin
        it.ppu_cycle = IRQ_CLOCK_DOT;
        it.rendering = 1'b1;
      end
    end else if (pick < 60) begin
      it = fresh_item(REQ_CPU_WRITE);
      if ($urandom_range(0, 9) != 0) it.cpu_addr[15] = 1'b1;
      if (it.cpu_addr[14:13] == WGRP_IRQ) begin
        r = $urandom_range(0, 9);
        if (r < 3) it.cpu_addr[1:0] = IRQ_SEL_LATCH;
        else if (r < 6) it.cpu_addr[1:0] = IRQ_SEL_RELOAD;
        else if (r < 9) it.cpu_addr[1:0] = IRQ_SEL_ENABLE;
        else it.cpu_addr[1:0] = IRQ_SEL_DISABLE;
        // short reload periods make the counter hit zero often
        if (r < 3 && $urandom_range(0, 3) != 0)
          it.write_data = 8'hFF - 8'($urandom_range(0, 5));
      end
    end else if (pick < 80) begin
      it = fresh_item(REQ_PRG_XLATE);
    end else begin
      it = fresh_item(REQ_CHR_XLATE);
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= it.req_type;
    cpu_addr   <= it.cpu_addr;
    write_data <= it.write_data;
    ppu_addr   <= it.ppu_addr;
    ppu_cycle  <= it.ppu_cycle;
    rendering  <= it.rendering;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_masks(input logic [7:0] prg_m, input logic [7:0] chr_m);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PRG_MASK;
    cfg_data  <= prg_m;
    @(posedge clk);
    cfg_index <= CFG_CHR_MASK;
    cfg_data  <= chr_m;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.prg_mask = prg_m;
    tracker.chr_mask = chr_m;
  endtask

  task automatic wait_drained();
    while (tracker.owed_translations.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls per result, calm stretches and one long hold-off
  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      hold = rx_calm ? 0 : $urandom_range(0, 14);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        tracker.check_result(map_result_t'{
          xlate_t'{prg_rom_addr, prg_hit, chr_rom_addr, nametable_a10}, irq_line});
      if (in_valid && !in_stall)
        tracker.note_item(item_t'{req_t'(req_type), cpu_addr, write_data, ppu_addr,
                                  ppu_cycle, rendering});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    item_t      opening [$];
    logic [7:0] prg_setting [PHASES];
    logic [7:0] chr_setting [PHASES];
    prg_setting = '{8'hFF, 8'h01, 8'hFE, 8'h01, 8'h3F, 8'hFF};
    chr_setting = '{8'hFF, 8'h00, 8'h80, 8'h00, 8'h1F, 8'hFF};
    prg_setting[3] = 8'($urandom_range(1, 255));
    chr_setting[3] = 8'($urandom_range(0, 255));

    opening.push_back(prg_item(16'h7FFF));          // below program space
    opening.push_back(prg_item(16'h8000));
    opening.push_back(prg_item(16'hFFFF));          // fixed last bank
    opening.push_back(chr_item(14'h3FFF));          // nametable area
    opening.push_back(chr_item(14'h0000));
    opening.push_back(write_item(16'h7FFF, 8'hFF)); // ignored write
    opening.push_back(write_item(16'h8000, 8'hFF));
    opening.push_back(write_item(16'h8001, 8'h80));
    opening.push_back(write_item(16'h8002, 8'hFF));
    opening.push_back(write_item(16'hA003, 8'h00));
    opening.push_back(write_item(16'hE000, 8'h40)); // mirror on
    opening.push_back(write_item(16'hE001, 8'h00)); // ignored, low bits set
    opening.push_back(chr_item(14'h0C00));
    opening.push_back(chr_item(14'h1FFF));
    opening.push_back(chr_item(14'h2800));
    opening.push_back(write_item(16'hC000, 8'hFE)); // reload value 1
    opening.push_back(write_item(16'hC001, 8'h00)); // reload request
    opening.push_back(write_item(16'hC002, 8'h00)); // enable
    opening.push_back(tick_item(IRQ_CLOCK_DOT, 1'b1));
    opening.push_back(tick_item(9'd263, 1'b1));
    opening.push_back(tick_item(IRQ_CLOCK_DOT, 1'b0));
    opening.push_back(tick_item(IRQ_CLOCK_DOT, 1'b1)); // counter reaches zero
    opening.push_back(prg_item(16'hA000));
    opening.push_back(write_item(16'hC003, 8'h00)); // disable and acknowledge
    opening.push_back(tick_item(9'd340, 1'b1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      write_masks(prg_setting[p], chr_setting[p]);
      if (p == 0) foreach (opening[i]) send_item(opening[i]);
      if (p == 2) long_hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_item(random_item());
      in_valid <= 1'b0;
      wait_drained();
    end
    if (tracker.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
src/cbm_pkg.sv
src/cbm_in_stage.sv
src/cbm_state.sv
src/cbm_xlate.sv
src/cartridge_bank_mapper_scanline_irq.sv
tb/cartridge_bank_mapper_scanline_irq_tb.sv
